### src/smf_pkg.sv
// shared types and constants of the serial port mux framer
package smf_pkg;

   localparam int BATCH_MAX = 3;

   localparam logic REQ_RX = 1'b0;
   localparam logic REQ_TX = 1'b1;

   localparam logic [1:0] KIND_LINE    = 2'd0;
   localparam logic [1:0] KIND_DELIVER = 2'd1;
   localparam logic [1:0] KIND_REFUSED = 2'd2;

   localparam logic [1:0] PHASE_UNSYNC = 2'd0;
   localparam logic [1:0] PHASE_SELECT = 2'd1;
   localparam logic [1:0] PHASE_RUN    = 2'd2;

   localparam logic [3:0] CMD_HIGH = 4'hF;
   localparam logic [3:0] LOW_MASK = 4'hF;
   localparam logic [7:0] CMD_ESC  = 8'hFF;

   localparam logic CSR_SYNC_BYTE = 1'b0;
   localparam logic CSR_PORT_MASK = 1'b1;

   localparam logic [7:0] SYNC_BYTE_RESET = 8'hFE;
   localparam logic [3:0] PORT_MASK_RESET = 4'h0;

   typedef struct packed {
      logic       req_type;
      logic [3:0] port;
      logic [7:0] data_byte;
   } req_data_type;

   typedef struct packed {
      logic [1:0] result_kind;
      logic [3:0] out_port;
      logic [7:0] out_byte;
      logic       last;
   } rsp_data_type;

   typedef struct packed {
      logic [1:0] link_phase;
      logic [3:0] rx_current_port;
      logic       rx_escape_pending;
      logic [3:0] tx_current_port;
      logic       tx_port_valid;
   } state_type;

   typedef struct packed {
      logic [1:0]                        count;
      rsp_data_type [BATCH_MAX-1:0]      results;
   } batch_type;

endpackage

### src/smf_stream_if.sv
// valid/ready stream channel carrying one payload struct
interface smf_stream_if #(
   parameter type data_type = logic
);
   logic     valid;
   logic     ready;
   data_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### src/smf_engine.sv
// decode of one request: results and next link state
module smf_engine #(
   parameter int NUM_PORTS = 4
) (
   input  smf_pkg::req_data_type item,
   input  smf_pkg::state_type    cur,
   input  logic [7:0]            sync_byte,
   input  logic [3:0]            port_mask,
   output smf_pkg::state_type    nxt,
   output smf_pkg::batch_type    batch
);

   localparam logic [3:0] NumPortsW = 4'(NUM_PORTS);

   logic [3:0] low;
   logic       is_cmd;
   logic [1:0] n;
   smf_pkg::rsp_data_type [smf_pkg::BATCH_MAX-1:0] res;

   function automatic logic port_open(input logic [3:0] p, input logic [3:0] mask);
      return (p < NumPortsW) && (p < 4'd4) && mask[p[1:0]];
   endfunction

   function automatic smf_pkg::rsp_data_type mk(input logic [1:0] kind,
                                                 input logic [3:0] p,
                                                 input logic [7:0] b);
      smf_pkg::rsp_data_type r;
      r.result_kind = kind;
      r.out_port    = p;
      r.out_byte    = b;
      r.last        = 1'b0;
      return r;
   endfunction

   assign low    = item.data_byte[3:0];
   assign is_cmd = item.data_byte[7:4] == smf_pkg::CMD_HIGH;

   always_comb begin
      nxt = cur;
      n   = 2'd0;
      res = '0;
      if (item.req_type == smf_pkg::REQ_RX) begin
         case (cur.link_phase)
            smf_pkg::PHASE_UNSYNC: begin
               if (item.data_byte == sync_byte) begin
                  nxt.link_phase = smf_pkg::PHASE_SELECT;
               end else begin
                  res[0] = mk(smf_pkg::KIND_LINE, 4'd0, sync_byte);
                  n      = 2'd1;
               end
            end
            smf_pkg::PHASE_SELECT: begin
               if (is_cmd && low < NumPortsW && low != smf_pkg::LOW_MASK) begin
                  nxt.rx_current_port   = low;
                  nxt.rx_escape_pending = 1'b0;
                  nxt.link_phase        = smf_pkg::PHASE_RUN;
               end
            end
            default: begin
               if (cur.rx_escape_pending) begin
                  nxt.rx_escape_pending = 1'b0;
                  if (port_open(cur.rx_current_port, port_mask)) begin
                     res[0] = mk(smf_pkg::KIND_DELIVER, cur.rx_current_port, item.data_byte);
                     n      = 2'd1;
                  end
               end else if (is_cmd) begin
                  if (low == smf_pkg::LOW_MASK) begin
                     nxt.rx_escape_pending = 1'b1;
                  end else if (low < NumPortsW) begin
                     nxt.rx_current_port = low;
                  end
               end else if (port_open(cur.rx_current_port, port_mask)) begin
                  res[0] = mk(smf_pkg::KIND_DELIVER, cur.rx_current_port, item.data_byte);
                  n      = 2'd1;
               end
            end
         endcase
      end else begin
         if (cur.link_phase == smf_pkg::PHASE_UNSYNC || !port_open(item.port, port_mask)) begin
            res[0] = mk(smf_pkg::KIND_REFUSED, item.port, item.data_byte);
            n      = 2'd1;
         end else begin
            if (!cur.tx_port_valid || cur.tx_current_port != item.port) begin
               nxt.tx_current_port = item.port;
               nxt.tx_port_valid   = 1'b1;
               res[n] = mk(smf_pkg::KIND_LINE, 4'd0, {smf_pkg::CMD_HIGH, item.port});
               n      = 2'(n + 2'd1);
            end
            if (is_cmd) begin
               res[n] = mk(smf_pkg::KIND_LINE, 4'd0, smf_pkg::CMD_ESC);
               n      = 2'(n + 2'd1);
            end
            res[n] = mk(smf_pkg::KIND_LINE, 4'd0, item.data_byte);
            n      = 2'(n + 2'd1);
         end
      end
      if (n != 2'd0) begin
         res[2'(n - 2'd1)].last = 1'b1;
      end
   end

   assign batch.count   = n;
   assign batch.results = res;

endmodule

### src/smf_rsp_queue.sv
// result register bank that hands out up to three results of one request
module smf_rsp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  smf_pkg::batch_type   batch,
   output logic                 free,
   smf_stream_if.source         rsp_ch
);

   smf_pkg::rsp_data_type [smf_pkg::BATCH_MAX-1:0] entries_ff;
   logic [1:0] cnt_ff, cnt_in;
   logic [1:0] rd_ff, rd_in;
   logic       busy;
   logic       drain;
   logic       drain_last;

   assign busy         = rd_ff != cnt_ff;
   assign rsp_ch.valid = busy;
   assign rsp_ch.data  = entries_ff[rd_ff];
   assign drain        = busy && rsp_ch.ready;
   assign drain_last   = drain && (2'(rd_ff + 2'd1) == cnt_ff);
   assign free         = !busy || drain_last;

   always_comb begin
      cnt_in = cnt_ff;
      rd_in  = rd_ff;
      if (load) begin
         cnt_in = batch.count;
         rd_in  = 2'd0;
      end else if (drain_last) begin
         cnt_in = 2'd0;
         rd_in  = 2'd0;
      end else if (drain) begin
         rd_in = 2'(rd_ff + 2'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         rd_ff  <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         entries_ff <= batch.results;
      end
   end

endmodule

### src/serial_port_mux_framer.sv
// top level of the serial port mux framer
//
// req_ch takes one request per handshake: a byte received from the line
// (req_type 0) or a payload byte a port wants to send (req_type 1).
// rsp_ch returns the results of each request in order, last marking the
// final one; a request may give zero, one, two or three results.
// csr_wr_en writes csr_wdata into register csr_index (0 sync byte,
// 1 port open mask); write only while no request is in flight.
// A request is registered in the input register, its results then in the
// result register bank. Throughput: one request per cycle while each gives
// at most one result and rsp_ch is ready; more results hold the input
// register while the single result register bank drains one entry per cycle.
// Reset (synchronous, active high) empties both stages, puts the link in
// the unsynchronised phase and loads the register reset values.
// When rsp_ch stalls, the result bank holds and one more request waits in
// the input register; req_ch.ready drops only once both are full.
module serial_port_mux_framer #(
   parameter int NUM_PORTS = 4
) (
   input  logic         clock,
   input  logic         reset,
   smf_stream_if.sink   req_ch,
   smf_stream_if.source rsp_ch,
   input  logic         csr_wr_en,
   input  logic         csr_index,
   input  logic [7:0]   csr_wdata
);

   logic                  in_valid_ff, in_valid_in;
   smf_pkg::req_data_type in_data_ff;
   smf_pkg::state_type    state_ff, state_in;
   logic [7:0]            sync_byte_ff;
   logic [3:0]            port_mask_ff;
   smf_pkg::batch_type    batch;
   logic                  queue_free;
   logic                  process;
   logic                  accept;

   assign process      = in_valid_ff && queue_free;
   assign req_ch.ready = !in_valid_ff || process;
   assign accept       = req_ch.valid && req_ch.ready;
   assign in_valid_in  = accept || (in_valid_ff && !process);

   smf_engine #(
      .NUM_PORTS (NUM_PORTS)
   ) u_engine (
      .item      (in_data_ff),
      .cur       (state_ff),
      .sync_byte (sync_byte_ff),
      .port_mask (port_mask_ff),
      .nxt       (state_in),
      .batch     (batch)
   );

   smf_rsp_queue u_rsp_queue (
      .clock  (clock),
      .reset  (reset),
      .load   (process),
      .batch  (batch),
      .free   (queue_free),
      .rsp_ch (rsp_ch)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         state_ff     <= '0;
         sync_byte_ff <= smf_pkg::SYNC_BYTE_RESET;
         port_mask_ff <= smf_pkg::PORT_MASK_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         if (process) begin
            state_ff <= state_in;
         end
         if (csr_wr_en) begin
            case (csr_index)
               smf_pkg::CSR_SYNC_BYTE: sync_byte_ff <= csr_wdata;
               smf_pkg::CSR_PORT_MASK: port_mask_ff <= csr_wdata[3:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_ch.data;
      end
   end

   a_hold_pending: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !process |=> in_valid_ff && $stable(in_data_ff))
      else $error("pending request lost or changed");

   a_last_marked: assert property (@(posedge clock) disable iff (reset)
      process && batch.count != 2'd0 |-> batch.results[2'(batch.count - 2'd1)].last)
      else $error("final result of a request not marked last");

   a_no_skip_select: assert property (@(posedge clock) disable iff (reset)
      process && state_ff.link_phase == smf_pkg::PHASE_UNSYNC
      |=> state_ff.link_phase != smf_pkg::PHASE_RUN)
      else $error("link left unsync phase straight into running");

   a_tx_port_sticky: assert property (@(posedge clock) disable iff (reset)
      state_ff.tx_port_valid |=> state_ff.tx_port_valid)
      else $error("tx port selection dropped");

endmodule
